@@ hdl/vpv_pkg.sv @@
// shared types, constants and pattern tables for the vcard profile validator
package vpv_pkg;

    localparam int PAT_COUNT = 9;
    localparam int PAT_CHARS = 11;
    localparam int PAT_BITS  = PAT_CHARS * 8;

    localparam logic [3:0] LEN_SAT = 4'd12;

    localparam logic [3:0] P_BEGIN   = 4'd0;
    localparam logic [3:0] P_VERSION = 4'd1;
    localparam logic [3:0] P_FN      = 4'd2;
    localparam logic [3:0] P_ORG     = 4'd3;
    localparam logic [3:0] P_ADR     = 4'd4;
    localparam logic [3:0] P_TEL     = 4'd5;
    localparam logic [3:0] P_EMAIL   = 4'd6;
    localparam logic [3:0] P_ENDPFX  = 4'd7;
    localparam logic [3:0] P_END     = 4'd8;

    localparam logic [3:0] PAT_LEN [PAT_COUNT] =
        '{4'd11, 4'd11, 4'd3, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd9};

    localparam logic [PAT_COUNT-1:0] MASK_ALL = '1;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [1:0] {
        PH_BEGIN   = 2'd0,
        PH_VERSION = 2'd1,
        PH_BODY    = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_VALID       = 4'd0,
        ST_PREMATURE   = 4'd1,
        ST_LONE_CR     = 4'd2,
        ST_NO_CRLF     = 4'd3,
        ST_BAD_BEGIN   = 4'd4,
        ST_BAD_VERSION = 4'd5,
        ST_UNEXPECTED  = 4'd6,
        ST_BAD_END     = 4'd7,
        ST_TRAILING    = 4'd8,
        ST_NO_FN       = 4'd9,
        ST_NO_CONTACT  = 4'd10
    } status_t;

    typedef struct packed {
        phase_t                 phase;
        logic [3:0]             line_length;
        logic [PAT_COUNT-1:0]   match_mask;
        logic                   pending_cr;
        logic                   pending_crlf;
        logic                   name_seen;
        logic                   contact_seen;
        status_t                error_code;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:        PH_BEGIN,
        line_length:  4'd0,
        match_mask:   MASK_ALL,
        pending_cr:   1'b0,
        pending_crlf: 1'b0,
        name_seen:    1'b0,
        contact_seen: 1'b0,
        error_code:   ST_VALID
    };

    function automatic logic [7:0] pat_byte(input logic [3:0] k, input logic [3:0] pos);
        logic [PAT_BITS-1:0] text;
        logic [7:0]          ch;
        case (k)
            P_BEGIN:   text = "begin:vcard";
            P_VERSION: text = "version:4.0";
            P_FN:      text = {"fn:", 64'h0};
            P_ORG:     text = {"org:", 56'h0};
            P_ADR:     text = {"adr:", 56'h0};
            P_TEL:     text = {"tel:", 56'h0};
            P_EMAIL:   text = {"email:", 40'h0};
            P_ENDPFX:  text = {"end:", 56'h0};
            P_END:     text = {"end:vcard", 16'h0};
            default:   text = '0;
        endcase
        if (int'(pos) < PAT_CHARS) begin
            ch = text[(PAT_CHARS - 1 - int'(pos)) * 8 +: 8];
        end else begin
            ch = 8'h00;
        end
        return ch;
    endfunction

endpackage

@@ hdl/vpv_step.sv @@
// per-item line unfolding, pattern matching and status logic
module vpv_step (
    input  vpv_pkg::state_t  state_cur,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output vpv_pkg::state_t  state_next,
    output vpv_pkg::status_t status
);
    import vpv_pkg::*;

    state_t consumed;

    function automatic state_t feed(input state_t s, input logic [7:0] c);
        state_t     r;
        logic [7:0] lc;
        r  = s;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_DELTA : c;
        for (int k = 0; k < PAT_COUNT; k++) begin
            if (s.line_length < PAT_LEN[k] && pat_byte(4'(k), s.line_length) != lc) begin
                r.match_mask[k] = 1'b0;
            end
        end
        if (s.line_length < LEN_SAT) begin
            r.line_length = s.line_length + 4'd1;
        end
        return r;
    endfunction

    function automatic logic exact(input state_t s, input logic [3:0] k);
        return s.match_mask[k] && s.line_length == PAT_LEN[k];
    endfunction

    function automatic logic prefix(input state_t s, input logic [3:0] k);
        return s.match_mask[k] && s.line_length >= PAT_LEN[k];
    endfunction

    function automatic state_t end_line(input state_t s);
        state_t r;
        r = s;
        case (s.phase)
            PH_BEGIN: begin
                if (exact(s, P_BEGIN)) r.phase = PH_VERSION;
                else r.error_code = ST_BAD_BEGIN;
            end
            PH_VERSION: begin
                if (exact(s, P_VERSION)) r.phase = PH_BODY;
                else r.error_code = ST_BAD_VERSION;
            end
            PH_BODY: begin
                if (prefix(s, P_FN)) begin
                    r.name_seen = 1'b1;
                end else if (prefix(s, P_ORG) || prefix(s, P_ADR) || prefix(s, P_TEL)
                             || prefix(s, P_EMAIL)) begin
                    r.contact_seen = 1'b1;
                end else if (prefix(s, P_ENDPFX)) begin
                    if (exact(s, P_END)) r.phase = PH_DONE;
                    else r.error_code = ST_BAD_END;
                end else begin
                    r.error_code = ST_UNEXPECTED;
                end
            end
            default: begin
            end
        endcase
        r.line_length = 4'd0;
        r.match_mask  = MASK_ALL;
        return r;
    endfunction

    function automatic status_t final_checks(input state_t s);
        status_t r;
        if (!s.name_seen) r = ST_NO_FN;
        else if (!s.contact_seen) r = ST_NO_CONTACT;
        else r = ST_VALID;
        return r;
    endfunction

    // consume one byte
    always_comb begin
        state_t s;
        logic   go;
        s  = state_cur;
        go = 1'b0;
        if (s.error_code == ST_VALID) begin
            if (s.phase == PH_DONE) begin
                s.error_code = ST_TRAILING;
            end else begin
                go = 1'b1;
                if (s.pending_crlf) begin
                    s.pending_crlf = 1'b0;
                    if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
                        go = 1'b0;
                    end else begin
                        s = end_line(s);
                        if (s.error_code != ST_VALID) begin
                            go = 1'b0;
                        end else if (s.phase == PH_DONE) begin
                            s.error_code = ST_TRAILING;
                            go = 1'b0;
                        end
                    end
                end else if (s.pending_cr) begin
                    s.pending_cr = 1'b0;
                    if (data_byte == CH_LF) begin
                        s.pending_crlf = 1'b1;
                        go = 1'b0;
                    end else begin
                        s = feed(s, CH_CR);
                    end
                end
                if (go) begin
                    if (data_byte == CH_CR) s.pending_cr = 1'b1;
                    else s = feed(s, data_byte);
                end
            end
        end
        consumed = s;
    end

    // next state: back to reset after the last byte of a card
    always_comb begin
        if (last_byte) state_next = STATE_RESET;
        else state_next = consumed;
    end

    // status of the card, meaningful on the last byte
    always_comb begin
        state_t s;
        s = end_line(consumed);
        if (consumed.error_code != ST_VALID) begin
            status = consumed.error_code;
        end else if (consumed.pending_cr) begin
            status = ST_LONE_CR;
        end else if (consumed.pending_crlf) begin
            if (s.error_code != ST_VALID) status = s.error_code;
            else if (s.phase == PH_DONE) status = final_checks(s);
            else status = ST_PREMATURE;
        end else if (consumed.phase == PH_DONE) begin
            status = final_checks(consumed);
        end else begin
            status = ST_NO_CRLF;
        end
    end

endmodule

@@ hdl/vcard_profile_validator.sv @@
// top level of the vcard profile validator: item register, state and status register
// Takes one byte of a vCard per cycle and gives one status item on the byte marked
// last, then clears itself for the next card. Throughput is one byte per clock,
// sustained while the status item is taken; the status is registered once its last
// byte, held in the input register, fires. Each held byte passes the single-pass
// unfold and match logic (nine case-folded byte compares and the line checks)
// between the input register and the status register. Input stalls only while a
// last byte waits behind a status item that has not been taken.
module vcard_profile_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_status
);
    import vpv_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    status_t    status_reg;
    status_t    step_status;
    logic       fire;

    vpv_step u_step (
        .state_cur  (state_reg),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .state_next (state_next),
        .status     (step_status)
    );

    assign fire    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        if (s_valid && s_ready) in_valid_next = 1'b1;
        else if (fire) in_valid_next = 1'b0;
        else in_valid_next = in_valid_reg;
    end

    always_comb begin
        if (fire && in_last_reg) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (fire && in_last_reg) begin
            status_reg <= step_status;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = status_reg;

`ifndef ASSERT_OFF
    a_last_gives_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> m_valid)
        else $error("last byte did not produce a status item");

    a_clear_after_card: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> state_reg.phase == PH_BEGIN
            && state_reg.error_code == ST_VALID && !state_reg.pending_cr
            && !state_reg.pending_crlf)
        else $error("state not cleared after last byte");

    a_error_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.error_code != ST_VALID && !(fire && in_last_reg)
            |=> $stable(state_reg.error_code))
        else $error("latched error changed within a card");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_last_reg && m_valid && !m_ready)
        else $error("input stalled without a waiting status item");
`endif

endmodule
